FILE: src/lfu_pkg.sv
// Package: shared types and constants for the LFU cache.
package lfu_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0] value;
    } lfu_req_t;

    typedef struct packed {
        logic              hit;
        logic signed [VAL_W-1:0] read_value;
    } lfu_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic update;    // apply the state update and emit result
    } lfu_cmd_t;

endpackage

FILE: src/lfu_ctrl.sv
// Controller: two-step sequencer, capture then update.
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output lfu_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy        = (state_reg == ST_UPD);
    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.update  = (state_reg == ST_UPD);

endmodule

FILE: src/lfu_dp.sv
// Datapath: entry table, key match, victim select and update logic.
module lfu_dp
    import lfu_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lfu_cmd_t         cmd,
    input  lfu_req_t         req,
    input  logic [CAP_W-1:0] cap,
    output logic             res_valid,
    output lfu_rsp_t         res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam int PW = 1 << IW;

    logic                  valid_reg [DEPTH];
    logic [KEY_W-1:0]      key_reg   [DEPTH];
    logic [VAL_W-1:0]      val_reg   [DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_reg  [DEPTH];
    logic [IW-1:0]         rank_reg  [DEPTH];

    logic              func_reg;
    logic [KEY_W-1:0]  ikey_reg;
    logic [VAL_W-1:0]  ival_reg;

    // Match / victim / free results registered at capture
    logic          found_reg, full_reg, free_ok_reg, cap0_reg;
    logic [IW-1:0] fidx_reg, vidx_reg, free_reg;

    logic          found_c, free_c;
    logic [IW-1:0] fidx_c, vidx_c, free_c_idx;
    logic [NW-1:0] held_c;
    logic [NW-1:0] capc;

    // Victim tournament tree: leaves at PW+i, winner at node 1
    logic                   tv_c [2*PW];
    logic [COUNT_WIDTH-1:0] tc_c [2*PW];
    logic [IW-1:0]          tr_c [2*PW];
    logic [IW-1:0]          ti_c [2*PW];

    // Lookup, occupancy and free slot search
    always_comb
    begin
        found_c    = 1'b0;
        fidx_c     = '0;
        free_c     = 1'b0;
        free_c_idx = '0;
        held_c     = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (valid_reg[i])
            begin
                held_c = held_c + NW'(1);
                if (!found_c && key_reg[i] == req.key)
                begin
                    found_c = 1'b1;
                    fidx_c  = IW'(i);
                end
            end
            else if (!free_c)
            begin
                free_c     = 1'b1;
                free_c_idx = IW'(i);
            end
        end
        if (32'(cap) > DEPTH)
            capc = NW'(DEPTH);
        else
            capc = NW'(cap);
    end

    // Victim: lowest count, then oldest (highest rank), pairwise tree
    always_comb
    begin
        for (int n = 0; n < 2*PW; n++)
        begin
            tv_c[n] = 1'b0;
            tc_c[n] = '0;
            tr_c[n] = '0;
            ti_c[n] = '0;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            tv_c[PW+i] = valid_reg[i];
            tc_c[PW+i] = cnt_reg[i];
            tr_c[PW+i] = rank_reg[i];
            ti_c[PW+i] = IW'(i);
        end
        for (int n = PW - 1; n >= 1; n--)
        begin
            if (tv_c[2*n] && (!tv_c[2*n+1] || tc_c[2*n] < tc_c[2*n+1] ||
                (tc_c[2*n] == tc_c[2*n+1] && tr_c[2*n] > tr_c[2*n+1])))
            begin
                tv_c[n] = tv_c[2*n];
                tc_c[n] = tc_c[2*n];
                tr_c[n] = tr_c[2*n];
                ti_c[n] = ti_c[2*n];
            end
            else
            begin
                tv_c[n] = tv_c[2*n+1];
                tc_c[n] = tc_c[2*n+1];
                tr_c[n] = tr_c[2*n+1];
                ti_c[n] = ti_c[2*n+1];
            end
        end
        vidx_c = ti_c[1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= req.func;
            ikey_reg    <= req.key;
            ival_reg    <= req.value;
            found_reg   <= found_c;
            fidx_reg    <= fidx_c;
            vidx_reg    <= vidx_c;
            free_reg    <= free_c_idx;
            free_ok_reg <= free_c;
            full_reg    <= (held_c >= capc) && (held_c != '0);
            cap0_reg    <= (capc == '0);
        end
    end

    // Update step: counts, recency and insertion
    logic do_use, do_ins, do_evict;
    logic [IW-1:0] ins_idx;
    assign do_use   = cmd.update && !cap0_reg && found_reg;
    assign do_evict = cmd.update && !cap0_reg && !found_reg &&
                      (func_reg == FUNC_PUT) && full_reg;
    assign ins_idx  = do_evict ? vidx_reg : free_reg;
    assign do_ins   = cmd.update && !cap0_reg && !found_reg &&
                      (func_reg == FUNC_PUT) && (do_evict || free_ok_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (do_ins)
            valid_reg[ins_idx] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_use)
            begin
                if (IW'(i) == fidx_reg)
                begin
                    rank_reg[i] <= '0;
                    if (cnt_reg[i] != '1)
                        cnt_reg[i] <= cnt_reg[i] + COUNT_WIDTH'(1);
                    if (func_reg == FUNC_PUT)
                        val_reg[i] <= ival_reg;
                end
                else if (valid_reg[i] && rank_reg[i] < rank_reg[fidx_reg])
                    rank_reg[i] <= rank_reg[i] + IW'(1);
            end
            else if (do_ins)
            begin
                if (IW'(i) == ins_idx)
                begin
                    rank_reg[i] <= '0;
                    cnt_reg[i]  <= COUNT_WIDTH'(1);
                    key_reg[i]  <= ikey_reg;
                    val_reg[i]  <= ival_reg;
                end
                else if (valid_reg[i] &&
                         (!do_evict || rank_reg[i] < rank_reg[vidx_reg]))
                    rank_reg[i] <= rank_reg[i] + IW'(1);
            end
        end
    end

    // Result for gets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid <= 1'b0;
        else
            res_valid <= cmd.update && (func_reg == FUNC_GET);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res.hit        <= do_use;
            res.read_value <= do_use ? val_reg[fidx_reg] : '0;
        end
    end

endmodule

FILE: src/lfu_cache.sv
// Top level: LFU cache with LRU tiebreak.
//   channel  | handshake          | payload
//   request  | start / busy       | req (func, key, value)
//   result   | done strobe        | rsp (hit, read_value)
//   config   | cap_we             | cap_wdata
// Each item is handled as lookup and victim search, then the table update.
// Get results appear in the cycle after the update, for one cycle on done.
// Reset clears all valid bits and sets capacity to 16; results cannot be held off.
module lfu_cache
    import lfu_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lfu_req_t         req,
    output logic             done,
    output lfu_rsp_t         rsp,
    input  logic             cap_we,
    input  logic [CAP_W-1:0] cap_wdata
);

    lfu_cmd_t         cmd;
    logic [CAP_W-1:0] cap_reg;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_W'(16);
        else if (cap_we)
            cap_reg <= cap_wdata;
    end

    lfu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    lfu_dp #(
        .DEPTH       (DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cap       (cap_reg),
        .res_valid (done),
        .res       (rsp)
    );

endmodule

FILE: tb/lfu_cache_tb.sv
// Testbench for lfu_cache: directed and random get/put traffic checked against a behavioral cache.
module lfu_cache_tb;
    import lfu_pkg::*;

    localparam int DEPTH     = 16;
    localparam int CNT_WIDTH = 4;
    localparam int CNT_MAX   = 15;
    localparam int MAX_GAP   = 30;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    lfu_req_t         req;
    logic             done;
    lfu_rsp_t         rsp;
    logic             cap_we;
    logic [CAP_W-1:0] cap_wdata;

    // behavioral cache state
    bit               ent_valid [DEPTH];
    logic [KEY_W-1:0] ent_key   [DEPTH];
    logic [VAL_W-1:0] ent_val   [DEPTH];
    int unsigned      ent_cnt   [DEPTH];
    int unsigned      ent_rank  [DEPTH];
    int unsigned      cache_cap;

    lfu_rsp_t         pending_reads [$];
    int               errors;
    logic [KEY_W-1:0] key_pool [8];

    // narrow counter so saturation is reachable
    lfu_cache #(.DEPTH(DEPTH), .COUNT_WIDTH(CNT_WIDTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cap_we    (cap_we),
        .cap_wdata (cap_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    // make entry i most recent
    function automatic void promote(int i);
        int unsigned r;
        r = ent_rank[i];
        for (int j = 0; j < DEPTH; j++)
            if (ent_valid[j] && ent_rank[j] < r)
                ent_rank[j]++;
        ent_rank[i] = 0;
    endfunction

    function automatic void count_use(int i);
        if (ent_cnt[i] < CNT_MAX)
            ent_cnt[i]++;
        promote(i);
    endfunction

    // apply one accepted item to the cache model, queue the read result
    function automatic void predict_cache(lfu_req_t r);
        int found, held, victim, slot, eff_cap;
        lfu_rsp_t res;
        found = -1;
        held = 0;
        victim = -1;
        slot = -1;
        eff_cap = (cache_cap > DEPTH) ? DEPTH : cache_cap;
        for (int i = 0; i < DEPTH; i++)
            if (ent_valid[i])
            begin
                held++;
                if (found < 0 && ent_key[i] == r.key)
                    found = i;
            end
        if (r.func == FUNC_GET)
        begin
            res = '0;
            if (eff_cap != 0 && found >= 0)
            begin
                res.hit = 1'b1;
                res.read_value = ent_val[found];
                count_use(found);
            end
            pending_reads.push_back(res);
            return;
        end
        if (eff_cap == 0)
            return;
        if (found >= 0)
        begin
            ent_val[found] = r.value;
            count_use(found);
            return;
        end
        if (held >= eff_cap && held > 0)
        begin
            for (int i = 0; i < DEPTH; i++)
                if (ent_valid[i] && (victim < 0 || ent_cnt[i] < ent_cnt[victim] ||
                    (ent_cnt[i] == ent_cnt[victim] && ent_rank[i] > ent_rank[victim])))
                    victim = i;
            ent_valid[victim] = 1'b0;
            for (int i = 0; i < DEPTH; i++)
                if (ent_valid[i] && ent_rank[i] > ent_rank[victim])
                    ent_rank[i]--;
        end
        for (int i = 0; i < DEPTH; i++)
            if (!ent_valid[i] && slot < 0)
                slot = i;
        if (slot < 0)
            return;
        for (int j = 0; j < DEPTH; j++)
            if (ent_valid[j])
                ent_rank[j]++;
        ent_valid[slot] = 1'b1;
        ent_key[slot] = r.key;
        ent_val[slot] = r.value;
        ent_cnt[slot] = 1;
        ent_rank[slot] = 0;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        lfu_rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("result with nothing expected: hit %0d read_value %0d",
                       rsp.hit, rsp.read_value);
                errors++;
            end
            else
            begin
                exp_rsp = pending_reads.pop_front();
                if (rsp.hit !== exp_rsp.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_rsp.hit, rsp.hit);
                    errors++;
                end
                if (rsp.read_value !== exp_rsp.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           exp_rsp.read_value, rsp.read_value);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_GAP) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(negedge clk);
    endtask

    // send one item from a falling edge; returns after acceptance, at a falling edge
    task automatic send_item(logic fn, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        lfu_req_t r;
        r.func = fn;
        r.key = k;
        r.value = v;
        req = r;
        start = 1'b1;
        // busy only moves at rising edges, so its value here holds at the next one
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_cache(r);
        @(negedge clk);
        start = 1'b0;
        idle_gap();
    endtask

    task automatic drain();
        while (pending_reads.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_capacity(int unsigned c);
        drain();
        cap_wdata <= c[CAP_W-1:0];
        cap_we <= 1'b1;
        @(negedge clk);
        cap_we <= 1'b0;
        cache_cap = c;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        return ($urandom_range(0, 7) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
    endfunction

    // extremes, misses, hits, updates, eviction order
    task automatic test_directed();
        send_item(FUNC_GET, 32'h0, 32'h0);
        send_item(FUNC_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(FUNC_PUT, 32'h0, 32'h7FFF_FFFF);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(FUNC_GET, 32'h0, 32'hFFFF_FFFF);
        send_item(FUNC_PUT, 32'h0, 32'hFFFF_FFFF);
        send_item(FUNC_GET, 32'h0, 32'h0);
        send_item(FUNC_GET, 32'h1234_5678, 32'h0);
        // fill beyond a capacity of 2 to force eviction by count
        write_capacity(2);
        send_item(FUNC_PUT, 32'hA, 32'h1);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(FUNC_GET, 32'h0, 32'h0);
        send_item(FUNC_GET, 32'hA, 32'h0);
        send_item(FUNC_PUT, 32'hB, 32'h2);
        send_item(FUNC_GET, 32'hB, 32'h0);
        // capacity zero: gets miss, puts ignored
        write_capacity(0);
        send_item(FUNC_PUT, 32'hC, 32'h3);
        send_item(FUNC_GET, 32'hB, 32'h0);
        send_item(FUNC_GET, 32'hC, 32'h0);
        // capacity above depth acts as depth
        write_capacity(31);
        send_item(FUNC_GET, 32'hB, 32'h0);
        send_item(FUNC_PUT, 32'h5555_AAAA, 32'h5555_AAAA);
        send_item(FUNC_GET, 32'h5555_AAAA, 32'h0);
        drain();
    endtask

    // two keys driven past the count limit: the tie then goes to the older one
    task automatic test_saturation();
        write_capacity(2);
        send_item(FUNC_PUT, 32'hDEAD_BEEF, 32'h1);
        repeat (25) send_item(FUNC_GET, 32'hDEAD_BEEF, 32'h0);
        send_item(FUNC_PUT, 32'hCAFE_F00D, 32'h2);
        repeat (18) send_item(FUNC_PUT, 32'hCAFE_F00D, $urandom());
        send_item(FUNC_PUT, 32'h0BAD_CAFE, 32'h3);
        send_item(FUNC_GET, 32'hDEAD_BEEF, 32'h0);
        send_item(FUNC_GET, 32'hCAFE_F00D, 32'h0);
        send_item(FUNC_GET, 32'h0BAD_CAFE, 32'h0);
    endtask

    // random traffic over several capacities
    task automatic test_random();
        int unsigned caps [6] = '{1, 3, 8, 16, 0, 20};
        for (int p = 0; p < 6; p++)
        begin
            write_capacity(caps[p]);
            for (int k = 0; k < 8; k++)
                key_pool[k] = $urandom();
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int n = 0; n < 120; n++)
                send_item($urandom_range(0, 1), pick_key(), $urandom());
        end
        // shrink below the held count
        write_capacity(2);
        for (int n = 0; n < 40; n++)
            send_item($urandom_range(0, 1), pick_key(), $urandom());
        drain();
    endtask

    initial
    begin
        errors = 0;
        cache_cap = 16;
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_valid[i] = 1'b0;
            ent_cnt[i] = 0;
            ent_rank[i] = 0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cap_we = 1'b0;
        cap_wdata = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        test_saturation();
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
